### design/sptf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sptf_pkg: shared types and constants of the sink pixel tail flagger
// Item layouts of both channels, configuration register indexes and
// default values of the top level parameters.
// ----------------------------------------------------------------------------
package sptf_pkg;

  // Default geometry and number format
  localparam int unsigned COLUMNS_DEF    = 4096;
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS      = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FLAG_MASK = 2'd1;

  localparam logic [15:0] FLAG_MASK_RST = 16'd1024;

  // One pixel in
  typedef struct packed {
    logic [11:0]        column;
    logic               frame_start;
    logic signed [31:0] sink_value;
    logic signed [31:0] science_value;
    logic [15:0]        quality_in;
  } in_item_t;

  // One result out
  typedef struct packed {
    logic [15:0] quality_out;
    logic        flagged;
  } out_item_t;

endpackage

### design/sptf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sptf_ram: simple dual port RAM
// One write port and one read port, read data registered.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module sptf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/sink_pixel_tail_flagger_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sink_pixel_tail_flagger_top: sink pixel and tail flagger
// Flags sink pixels and their trailing tails per column and ORs the flag
// mask into the quality word of each flagged pixel.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   in       input      in_valid_i/_stall  sptf_pkg::in_item_t
//   out      output     out_valid_o/_stall sptf_pkg::out_item_t
//   cfg      input      cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// One item per clock unless the output stalls; an accepted item passes the
// update stage, then the result register. The column state RAM holds rows
// of 16 (32 above 4096 columns) entries; an item reads its row on acceptance,
// updates it in the update stage and writes it back, with the row forwarded
// to a following item of the same row. Reset and frame start clear the
// per-row valid flops at once, so no clearing pass is needed. A stall on the
// output holds the result register, then the update stage, then the input.
//
module sink_pixel_tail_flagger_top #(
  parameter int unsigned COLUMNS    = sptf_pkg::COLUMNS_DEF,
  parameter int unsigned VALUE_BITS = sptf_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // pixel input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  sptf_pkg::in_item_t                 in_item_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output sptf_pkg::out_item_t                out_item_o,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [sptf_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [sptf_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i
);

  localparam int unsigned LANES     = (COLUMNS > 4096) ? 32 : 16;
  localparam int unsigned LANE_BITS = $clog2(LANES);
  localparam int unsigned ROWS      = (COLUMNS + LANES - 1) / LANES;
  localparam int unsigned AW        = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned EW        = VALUE_BITS + 1;
  localparam int unsigned RW        = LANES * EW;

  localparam logic signed [VALUE_BITS-1:0] MINUS_ONE =
    VALUE_BITS'(-(1 << sptf_pkg::FRAC_BITS));

  // Configuration registers
  logic        enable_q;
  logic [15:0] flag_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      flag_mask_q <= sptf_pkg::FLAG_MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sptf_pkg::CFG_ENABLE:    enable_q    <= cfg_wdata_i[0];
        sptf_pkg::CFG_FLAG_MASK: flag_mask_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake and stage control
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_adv;
  logic in_acc;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Row and lane of the incoming item
  logic [11:0]          in_col_shift;
  logic [AW-1:0]        in_row;
  logic [LANE_BITS-1:0] in_lane;
  logic                 in_range;

  assign in_col_shift = in_item_i.column >> LANE_BITS;
  assign in_row       = in_col_shift[AW-1:0];
  assign in_lane      = in_item_i.column[LANE_BITS-1:0];
  assign in_range     = 32'(in_item_i.column) < COLUMNS;

  // Update stage registers
  sptf_pkg::in_item_t   s1_item_q;
  logic [AW-1:0]        s1_row_q;
  logic [LANE_BITS-1:0] s1_lane_q;
  logic                 s1_range_q;

  // the stage loads whenever it is empty or its item moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q  <= in_item_i;
      s1_row_q   <= in_row;
      s1_lane_q  <= in_lane;
      s1_range_q <= in_range;
    end
  end

  // Column state RAM
  logic          wr_en;
  logic [RW-1:0] ram_rdata;
  logic [RW-1:0] row_new;

  sptf_ram #(
    .WIDTH (RW),
    .DEPTH (ROWS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_row_q),
    .wdata_i (row_new),
    .re_i    (in_acc),
    .raddr_i (in_row),
    .rdata_o (ram_rdata)
  );

  // Row valid flops and forwarding of a row written as it is read
  logic [ROWS-1:0] row_valid_q;
  logic [ROWS-1:0] row_valid_d;
  logic            fwd_hit_q;
  logic [RW-1:0]   fwd_row_q;

  // frame start clears every row, then the row written back is valid
  always_comb begin
    row_valid_d = row_valid_q;
    if (s1_valid_q && s1_adv && s1_item_q.frame_start) begin
      row_valid_d = '0;
    end
    if (wr_en) begin
      row_valid_d[s1_row_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      fwd_hit_q   <= 1'b0;
    end else begin
      row_valid_q <= row_valid_d;
      if (!in_stall_o) begin
        fwd_hit_q <= in_acc && wr_en && (in_row == s1_row_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_row_q <= row_new;
    end
  end

  // Read-modify-write of one column entry
  logic [RW-1:0]         row_base;
  logic [EW-1:0]         entry;
  logic                  tail;
  logic [VALUE_BITS-1:0] latched;
  logic [VALUE_BITS-1:0] sink_v;
  logic [VALUE_BITS-1:0] sci_v;
  logic                  tail_n;
  logic [VALUE_BITS-1:0] latched_n;
  logic                  flag;

  always_comb begin
    sink_v = VALUE_BITS'($unsigned(s1_item_q.sink_value));
    sci_v  = VALUE_BITS'($unsigned(s1_item_q.science_value));

    // rows not yet written in this frame read as cleared
    if (!s1_item_q.frame_start && row_valid_q[s1_row_q]) begin
      row_base = fwd_hit_q ? fwd_row_q : ram_rdata;
    end else begin
      row_base = '0;
    end
    entry   = row_base[s1_lane_q*EW +: EW];
    tail    = entry[VALUE_BITS];
    latched = entry[VALUE_BITS-1:0];

    tail_n    = tail;
    latched_n = latched;
    flag      = 1'b0;
    if (enable_q && s1_range_q) begin
      if (sink_v[VALUE_BITS-1]) begin
        // sink pixel: start or keep the tail
        tail_n = 1'b1;
        if ($signed(sink_v) < MINUS_ONE) begin
          latched_n = sci_v;
        end
        flag = 1'b1;
      end else if (sink_v != '0) begin
        // tail continues while the reference stays above the latched value
        if (tail) begin
          if ($signed(sink_v) > $signed(latched)) begin
            flag = 1'b1;
          end else begin
            tail_n = 1'b0;
          end
        end
      end else begin
        tail_n = 1'b0;
      end
    end

    row_new = row_base;
    row_new[s1_lane_q*EW +: EW] = {tail_n, latched_n};
  end

  assign wr_en = s1_valid_q && s1_adv && enable_q && s1_range_q;

  // Result register
  sptf_pkg::out_item_t out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_item_q.quality_out <= flag ? (s1_item_q.quality_in | flag_mask_q)
                                     : s1_item_q.quality_in;
      out_item_q.flagged     <= flag;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Assertions
  a_fwd_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> s1_valid_q)
    else $error("forwarded row without an item in the update stage");

  a_no_write_disabled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !enable_q |-> !wr_en)
    else $error("column state written while flagging is disabled");

  a_frame_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_adv && s1_item_q.frame_start && !wr_en) |=> (row_valid_q == '0))
    else $error("frame start left column rows valid");

  a_flag_has_mask : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.flagged)
      |-> ((out_item_q.quality_out & flag_mask_q) == flag_mask_q))
    else $error("flagged item lacks the flag mask bits");

endmodule
